@@ rtl/triaxial_block_averager_with_zero_cal_top_defines.svh @@
// Assertion macros shared by the block averager RTL.
`ifndef TRIAXIAL_BLOCK_AVERAGER_WITH_ZERO_CAL_TOP_DEFINES_SVH
`define TRIAXIAL_BLOCK_AVERAGER_WITH_ZERO_CAL_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define TBA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define TBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tba_pkg.sv @@
// Types and constants of the block averager.
package tba_pkg;

   // register indexes on the csr port
   localparam logic [1:0] REG_CAL_MODE  = 2'd0;
   localparam logic [1:0] REG_MEAS_LEN  = 2'd1;
   localparam logic [1:0] REG_CAL_LEN   = 2'd2;
   localparam logic [1:0] REG_GRAVITY   = 2'd3;

   // register reset values
   localparam logic [7:0]  MEAS_LEN_RESET = 8'd5;
   localparam logic [7:0]  CAL_LEN_RESET  = 8'd25;
   localparam logic [14:0] GRAVITY_RESET  = 15'd16000;

   // result kinds
   localparam logic KIND_MEASURE = 1'b0;
   localparam logic KIND_CAL     = 1'b1;

   // saturation limits of a corrected measurement
   localparam int SAT16_MAX = 32767;
   localparam int SAT16_MIN = -32768;

   localparam int VALUE_W = 17;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIVIDE,
      ST_WRITE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic load;
      logic step;
      logic write;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic run_done;
      logic div_last;
   } stat_type;

endpackage

@@ rtl/tba_ctrl.sv @@
// Controller: sequences accumulate, divider load, divide steps and result write.
`include "triaxial_block_averager_with_zero_cal_top_defines.svh"

module tba_ctrl import tba_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      write_go;

   // result may be written once the output register is free or being taken
   assign write_go = (state_ff == ST_WRITE) && (!out_valid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && stat.run_done) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (stat.div_last) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (write_go) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
         end
         ST_WRITE: begin
            cmd.write = write_go;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // output word valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (write_go)        out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   assign rsp_tvalid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   `TBA_ASSERT_NEXT(a_run_end_loads, clock, reset, (state_ff == ST_IDLE) && req_tvalid && stat.run_done, state_ff == ST_LOAD, "run end did not load divider")
   `TBA_ASSERT_NEXT(a_last_step_writes, clock, reset, (state_ff == ST_DIVIDE) && stat.div_last, state_ff == ST_WRITE, "divider end did not reach write")
   `TBA_ASSERT_NEXT(a_write_waits, clock, reset, (state_ff == ST_WRITE) && out_valid_ff && !rsp_tready, (state_ff == ST_WRITE) && out_valid_ff, "result written over pending word")

endmodule

@@ rtl/tba_dp.sv @@
// Datapath: config registers, axis sums, three-lane restoring divider, offsets, output word.
`include "triaxial_block_averager_with_zero_cal_top_defines.svh"

module tba_dp import tba_pkg::*; #(
   parameter int SUM_WIDTH = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [47:0] req_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata,
   output logic [55:0] rsp_tdata,
   output logic        rsp_tuser
);

   localparam int STEP_W = $clog2(SUM_WIDTH);
   localparam int OFS_W  = SUM_WIDTH + 1;
   localparam int DIFF_W = SUM_WIDTH + 2;

   // configuration
   logic        cal_mode_ff, cal_mode_in;
   logic [7:0]  meas_len_ff, meas_len_in;
   logic [7:0]  cal_len_ff, cal_len_in;
   logic [14:0] gravity_ff, gravity_in;
   logic        csr_clear;

   // run state
   logic [7:0]           count_ff, count_in;
   logic [SUM_WIDTH-1:0] sum_ff [3];
   logic [SUM_WIDTH-1:0] sum_in [3];
   logic [15:0]          sample [3];

   // divider
   logic [SUM_WIDTH-1:0] dvd_ff [3];
   logic [SUM_WIDTH-1:0] dvd_in [3];
   logic [7:0]           rem_ff [3];
   logic [7:0]           rem_in [3];
   logic [2:0]           neg_ff, neg_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [8:0]           shifted [3];
   logic [8:0]           trial [3];
   logic [2:0]           fits;

   // result
   logic [OFS_W-1:0]     ofs_ff [3];
   logic [OFS_W-1:0]     ofs_in [3];
   logic [SUM_WIDTH-1:0] avg [3];
   logic [OFS_W-1:0]     new_ofs [3];
   logic signed [DIFF_W-1:0] diff [3];
   logic [VALUE_W-1:0]   value [3];
   logic [VALUE_W-1:0]   out_val_ff [3];
   logic [VALUE_W-1:0]   out_val_in [3];
   logic                 out_kind_ff, out_kind_in;

   logic [7:0] len_sel, len_eff, count_next;

   // active run length, zero taken as one
   assign len_sel    = cal_mode_ff ? cal_len_ff : meas_len_ff;
   assign len_eff    = (len_sel == 8'd0) ? 8'd1 : len_sel;
   assign count_next = count_ff + 8'd1;

   assign stat.run_done = (count_next >= len_eff);
   assign stat.div_last = (step_ff == STEP_W'(SUM_WIDTH - 1));

   // configuration writes
   always_comb begin
      cal_mode_in = cal_mode_ff;
      meas_len_in = meas_len_ff;
      cal_len_in  = cal_len_ff;
      gravity_in  = gravity_ff;
      csr_clear   = 1'b0;
      if (csr_we) begin
         csr_clear = 1'b1;
         case (csr_index)
            REG_CAL_MODE: cal_mode_in = csr_wdata[0];
            REG_MEAS_LEN: meas_len_in = csr_wdata[7:0];
            REG_CAL_LEN:  cal_len_in  = csr_wdata[7:0];
            REG_GRAVITY:  gravity_in  = csr_wdata;
            default:      csr_clear   = 1'b0;
         endcase
      end
   end

   // sample fields: little-endian 16-bit per axis
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sample[i] = req_tdata[16*i +: 16];
      end
   end

   // accumulate, clear on run end or config write
   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < 3; i++) sum_in[i] = sum_ff[i];
      if (csr_clear || cmd.load) begin
         count_in = 8'd0;
         for (int i = 0; i < 3; i++) sum_in[i] = '0;
      end else if (cmd.accept) begin
         count_in = count_next;
         for (int i = 0; i < 3; i++) begin
            sum_in[i] = sum_ff[i] + {{(SUM_WIDTH-16){sample[i][15]}}, sample[i]};
         end
      end
   end

   // divider lanes: magnitude in, one quotient bit per step
   always_comb begin
      step_in = step_ff;
      neg_in  = neg_ff;
      for (int i = 0; i < 3; i++) begin
         shifted[i] = {rem_ff[i], dvd_ff[i][SUM_WIDTH-1]};
         trial[i]   = shifted[i] - {1'b0, len_eff};
         fits[i]    = (shifted[i] >= {1'b0, len_eff});
         dvd_in[i]  = dvd_ff[i];
         rem_in[i]  = rem_ff[i];
      end
      if (cmd.load) begin
         step_in = '0;
         for (int i = 0; i < 3; i++) begin
            neg_in[i] = sum_ff[i][SUM_WIDTH-1];
            dvd_in[i] = sum_ff[i][SUM_WIDTH-1] ? (~sum_ff[i] + 1'b1) : sum_ff[i];
            rem_in[i] = 8'd0;
         end
      end else if (cmd.step) begin
         step_in = step_ff + 1'b1;
         for (int i = 0; i < 3; i++) begin
            rem_in[i] = fits[i] ? trial[i][7:0] : shifted[i][7:0];
            dvd_in[i] = {dvd_ff[i][SUM_WIDTH-2:0], fits[i]};
         end
      end
   end

   // averages, new offsets and corrected values
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         avg[i]     = neg_ff[i] ? (~dvd_ff[i] + 1'b1) : dvd_ff[i];
         new_ofs[i] = {avg[i][SUM_WIDTH-1], avg[i]};
         diff[i]    = $signed({{2{avg[i][SUM_WIDTH-1]}}, avg[i]})
                    - $signed({ofs_ff[i][OFS_W-1], ofs_ff[i]});
         if (diff[i] > DIFF_W'(SAT16_MAX))      value[i] = VALUE_W'(SAT16_MAX);
         else if (diff[i] < DIFF_W'(SAT16_MIN)) value[i] = VALUE_W'(SAT16_MIN);
         else                                   value[i] = diff[i][VALUE_W-1:0];
      end
      // gravity comes off z only
      new_ofs[2] = {avg[2][SUM_WIDTH-1], avg[2]} - {{(OFS_W-15){1'b0}}, gravity_ff};
   end

   // result registers
   always_comb begin
      out_kind_in = out_kind_ff;
      for (int i = 0; i < 3; i++) begin
         ofs_in[i]     = ofs_ff[i];
         out_val_in[i] = out_val_ff[i];
      end
      if (cmd.write) begin
         if (cal_mode_ff) begin
            out_kind_in = KIND_CAL;
            for (int i = 0; i < 3; i++) begin
               ofs_in[i]     = new_ofs[i];
               out_val_in[i] = new_ofs[i][VALUE_W-1:0];
            end
         end else begin
            out_kind_in = KIND_MEASURE;
            for (int i = 0; i < 3; i++) out_val_in[i] = value[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_mode_ff <= 1'b0;
         meas_len_ff <= MEAS_LEN_RESET;
         cal_len_ff  <= CAL_LEN_RESET;
         gravity_ff  <= GRAVITY_RESET;
         count_ff    <= 8'd0;
         step_ff     <= '0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= '0;
            ofs_ff[i] <= '0;
         end
      end else begin
         cal_mode_ff <= cal_mode_in;
         meas_len_ff <= meas_len_in;
         cal_len_ff  <= cal_len_in;
         gravity_ff  <= gravity_in;
         count_ff    <= count_in;
         step_ff     <= step_in;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= sum_in[i];
            ofs_ff[i] <= ofs_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      out_kind_ff <= out_kind_in;
      for (int i = 0; i < 3; i++) begin
         dvd_ff[i]     <= dvd_in[i];
         rem_ff[i]     <= rem_in[i];
         out_val_ff[i] <= out_val_in[i];
      end
   end

   // tdata: x_value, y_value, z_value from bit 0, zero fill
   assign rsp_tdata = {5'd0, out_val_ff[2], out_val_ff[1], out_val_ff[0]};
   assign rsp_tuser = out_kind_ff;

   `TBA_ASSERT_NEXT(a_load_clears_run, clock, reset, cmd.load, (count_ff == 8'd0) && (sum_ff[0] == '0) && (sum_ff[2] == '0) && (step_ff == '0), "run not cleared at divider load")
   `TBA_ASSERT_NEXT(a_csr_clears_run, clock, reset, csr_we, (count_ff == 8'd0) && (sum_ff[1] == '0), "config write did not clear run")
   `TBA_ASSERT_NEXT(a_cal_word_is_offset, clock, reset, cmd.write && cal_mode_ff, (rsp_tuser == KIND_CAL) && (rsp_tdata[16:0] == ofs_ff[0][16:0]) && (rsp_tdata[50:34] == ofs_ff[2][16:0]), "calibration word differs from stored offsets")

endmodule

@@ rtl/triaxial_block_averager_with_zero_cal_top.sv @@
// Top level of the three-axis block averager with zero-offset calibration.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_tvalid/req_tready  | req_tdata: six sample bytes
//   rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata: three values, rsp_tuser: kind
//   csr     | in        | csr_we                 | csr_index, csr_wdata
//
// A sample that does not end a run is taken while the block is idle. A sample that ends a run
// is followed by the divider load, SUM_WIDTH restoring steps in the shared three-lane divider
// and the result write; no new sample is taken until that write is done.
// Reset is synchronous and active high; it restores register defaults, clears sums
// and offsets. A pending result does not stop accumulation; only the write of the next
// result waits until the output word is taken.
module triaxial_block_averager_with_zero_cal_top import tba_pkg::*; #(
   parameter int SUM_WIDTH = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // x_low_byte, x_high_byte, y_low_byte, y_high_byte, z_low_byte, z_high_byte
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // x_value [16:0], y_value [33:17], z_value [50:34], zero fill
   output logic [55:0] rsp_tdata,
   // result_kind
   output logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   tba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tba_dp #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

@@ sim/triaxial_block_averager_with_zero_cal_checker.sv @@
// Result checker for the block averager: tracks sample, result and register words.
module triaxial_block_averager_with_zero_cal_checker import tba_pkg::*; #(
   parameter int SUM_WIDTH = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata,
   output int          fail_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic               kind;
      logic signed [16:0] x;
      logic signed [16:0] y;
      logic signed [16:0] z;
   } axis_word_type;

   // shadow registers and run state
   logic                        cal_mode;
   logic [7:0]                  meas_len;
   logic [7:0]                  cal_len;
   logic [14:0]                 gravity;
   logic signed [SUM_WIDTH-1:0] axis_sum [3];
   logic [7:0]                  run_count;
   int                          zero_offset [3];

   axis_word_type pending_averages [$];

   task automatic clear_run();
      for (int a = 0; a < 3; a++) axis_sum[a] = '0;
      run_count = '0;
   endtask

   // adds one sample; queues the averaged word when the run completes
   task automatic accumulate_sample(input logic [47:0] sample);
      int                 len;
      int                 avg [3];
      int                 diff;
      logic signed [15:0] axis;
      axis_word_type      w;
      len = cal_mode ? int'(cal_len) : int'(meas_len);
      if (len == 0) len = 1;
      for (int a = 0; a < 3; a++) begin
         axis = sample[16*a +: 16];
         axis_sum[a] = axis_sum[a] + axis;
      end
      run_count = run_count + 8'd1;
      if (run_count < len) return;
      // signed division truncates toward zero
      for (int a = 0; a < 3; a++) avg[a] = int'(axis_sum[a]) / len;
      clear_run();
      if (cal_mode) begin
         zero_offset[0] = avg[0];
         zero_offset[1] = avg[1];
         zero_offset[2] = avg[2] - int'(gravity);
         w.kind = KIND_CAL;
         w.x = 17'(zero_offset[0]);
         w.y = 17'(zero_offset[1]);
         w.z = 17'(zero_offset[2]);
      end else begin
         w.kind = KIND_MEASURE;
         for (int a = 0; a < 3; a++) begin
            diff = avg[a] - zero_offset[a];
            if (diff > SAT16_MAX) diff = SAT16_MAX;
            if (diff < SAT16_MIN) diff = SAT16_MIN;
            avg[a] = diff;
         end
         w.x = 17'(avg[0]);
         w.y = 17'(avg[1]);
         w.z = 17'(avg[2]);
      end
      pending_averages.push_back(w);
   endtask

   task automatic report_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         fail_count++;
      end
   endtask

   // inputs and outputs all change on NBAs, so values read here are the ones
   // present at the edge
   always @(posedge clock) begin
      axis_word_type w;
      if (reset) begin
         cal_mode = 1'b0;
         meas_len = MEAS_LEN_RESET;
         cal_len  = CAL_LEN_RESET;
         gravity  = GRAVITY_RESET;
         for (int a = 0; a < 3; a++) zero_offset[a] = 0;
         clear_run();
         pending_averages.delete();
      end else begin
         // result word
         if (rsp_tvalid && rsp_tready) begin
            if (pending_averages.size() == 0) begin
               $display("%0t ns: result word with none expected, got kind %0d data %h",
                        $time, rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               w = pending_averages.pop_front();
               report_field("kind", int'(w.kind), int'(rsp_tuser));
               report_field("x", int'(w.x), int'($signed(rsp_tdata[16:0])));
               report_field("y", int'(w.y), int'($signed(rsp_tdata[33:17])));
               report_field("z", int'(w.z), int'($signed(rsp_tdata[50:34])));
               report_field("fill", 0, int'(rsp_tdata[55:51]));
            end
         end
         // register write; every index clears the run
         if (csr_we) begin
            case (csr_index)
               REG_CAL_MODE: cal_mode = csr_wdata[0];
               REG_MEAS_LEN: meas_len = csr_wdata[7:0];
               REG_CAL_LEN:  cal_len  = csr_wdata[7:0];
               REG_GRAVITY:  gravity  = csr_wdata;
               default: ;
            endcase
            clear_run();
         end
         // sample word
         if (req_tvalid && req_tready) accumulate_sample(req_tdata);
      end
      outstanding = pending_averages.size();
   end

endmodule

@@ sim/triaxial_block_averager_with_zero_cal_top_tb.sv @@
// Testbench top for the block averager: clock, reset, stimulus and verdict.
module triaxial_block_averager_with_zero_cal_top_tb import tba_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SUM_W       = 24;
   localparam int LATENCY     = SUM_W + 3;
   localparam int CYCLE_LIMIT = 500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = REG_CAL_MODE;
   logic [14:0] csr_wdata = '0;

   int fail_count;
   int outstanding;
   int cycle_count = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;

   triaxial_block_averager_with_zero_cal_top #(.SUM_WIDTH(SUM_W)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   triaxial_block_averager_with_zero_cal_checker #(.SUM_WIDTH(SUM_W)) checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("triaxial_block_averager_with_zero_cal_top test failed");
         $finish;
      end
   end

   function automatic logic [47:0] pack_sample(logic [15:0] x, logic [15:0] y,
                                               logic [15:0] z);
      return {z, y, x};
   endfunction

   function automatic logic [15:0] random_axis();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         // near zero, so corrected values stay small
         2: return 16'($urandom_range(0, 400) - 200);
         // near one g
         default: return 16'(15900 + $urandom_range(0, 200));
      endcase
   endfunction

   function automatic logic [7:0] pick_len(bit allow_long);
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd1;
         8: return 8'($urandom_range(9, 20));
         9: return allow_long ? 8'd255 : 8'($urandom_range(2, 8));
         default: return 8'($urandom_range(2, 8));
      endcase
   endfunction

   function automatic logic [14:0] pick_gravity();
      case ($urandom_range(0, 3))
         0: return 15'd0;
         1: return 15'h7FFF;
         2: return GRAVITY_RESET;
         default: return 15'($urandom);
      endcase
   endfunction

   // one sample word, with a random gap in front; returns after the accepting edge
   task automatic send_sample(input logic [47:0] sample);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < tx_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
   endtask

   // hold the sender until every expected word is out and the divider is quiet
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_settings(input logic mode, input logic [7:0] mlen,
                                 input logic [7:0] clen, input logic [14:0] grav);
      csr_we    <= 1'b1;
      csr_index <= REG_CAL_MODE;
      csr_wdata <= 15'(mode);
      @(posedge clock);
      csr_index <= REG_MEAS_LEN;
      csr_wdata <= 15'(mlen);
      @(posedge clock);
      csr_index <= REG_CAL_LEN;
      csr_wdata <= 15'(clen);
      @(posedge clock);
      csr_index <= REG_GRAVITY;
      csr_wdata <= grav;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // phases of random settings, each a few runs plus a partial run
   task automatic random_phases(input int count);
      int          sent;
      int          n;
      int          eff;
      logic        mode;
      logic [7:0]  mlen;
      logic [7:0]  clen;
      logic [14:0] grav;
      sent = 0;
      while (sent < count) begin
         mode = ($urandom_range(0, 99) < 30);
         mlen = pick_len(mode);
         clen = pick_len(!mode);
         grav = pick_gravity();
         wait_drained();
         write_settings(mode, mlen, clen, grav);
         eff = mode ? int'(clen) : int'(mlen);
         if (eff == 0) eff = 1;
         n = eff * $urandom_range(1, 4) + $urandom_range(0, eff - 1);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 2) wait_drained();
            send_sample(pack_sample(random_axis(), random_axis(), random_axis()));
            sent++;
         end
      end
      wait_drained();
   endtask

   initial begin
      tx_idle_pct = 21;
      rx_idle_pct = 60;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: measure, runs of five, full-scale x and y samples
      for (int i = 0; i < 5; i++) send_sample(pack_sample(16'h7FFF, 16'h8000, 16'hFFFF));
      for (int i = 0; i < 5; i++) send_sample(pack_sample(16'h8000, 16'h7FFF, 16'h0001));

      // calibrate at the extremes: z offset reaches its most negative value
      wait_drained();
      write_settings(1'b1, 8'd1, 8'd2, 15'h7FFF);
      for (int i = 0; i < 2; i++) send_sample(pack_sample(16'h7FFF, 16'h8000, 16'h8000));

      // corrections saturate both ways
      wait_drained();
      write_settings(1'b0, 8'd1, CAL_LEN_RESET, GRAVITY_RESET);
      send_sample(pack_sample(16'h8000, 16'h7FFF, 16'h7FFF));

      // zero run lengths act as one, in both modes
      wait_drained();
      write_settings(1'b0, 8'd0, 8'd0, 15'd0);
      for (int i = 0; i < 2; i++)
         send_sample(pack_sample(random_axis(), random_axis(), random_axis()));
      wait_drained();
      write_settings(1'b1, 8'd0, 8'd0, 15'd0);
      for (int i = 0; i < 2; i++)
         send_sample(pack_sample(random_axis(), random_axis(), random_axis()));

      // back-to-back calibrations; the first one checks truncation toward zero
      wait_drained();
      write_settings(1'b1, 8'd255, 8'd3, GRAVITY_RESET);
      send_sample(pack_sample(16'd1, 16'hFFFF, 16'd16001));
      send_sample(pack_sample(16'd1, 16'hFFFF, 16'd16001));
      send_sample(pack_sample(16'd0, 16'h0000, 16'd16001));
      for (int i = 0; i < 5; i++)
         send_sample(pack_sample(random_axis(), random_axis(), random_axis()));

      random_phases(150);

      tx_idle_pct = 60;
      rx_idle_pct = 21;
      // longest run with the sums close to their limits
      wait_drained();
      write_settings(1'b0, 8'd255, 8'd1, GRAVITY_RESET);
      for (int i = 0; i < 255; i++) send_sample(pack_sample(16'h8000, 16'h7FFF, random_axis()));
      random_phases(150);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      random_phases(150);

      // drain and verdict
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (fail_count == 0) begin
         $display("triaxial_block_averager_with_zero_cal_top test passed");
      end else begin
         $display("triaxial_block_averager_with_zero_cal_top test failed");
      end
      $finish;
   end

endmodule
